### design/kinl_pkg.sv
// Shared types and constants for the keyword, identifier and number lexer.
`default_nettype none

package kinl_pkg;

  // Token class codes carried in token_class.
  localparam logic [2:0] CLS_KEYWORD   = 3'd0;
  localparam logic [2:0] CLS_IDENT     = 3'd1;
  localparam logic [2:0] CLS_NUMBER    = 3'd2;
  localparam logic [2:0] CLS_OPERATOR  = 3'd3;
  localparam logic [2:0] CLS_SEMICOLON = 3'd4;

  // Keyword ids carried in keyword_id.
  localparam logic [1:0] KW_INT   = 2'd0;
  localparam logic [1:0] KW_FLOAT = 2'd1;
  localparam logic [1:0] KW_IF    = 2'd2;
  localparam logic [1:0] KW_ELSE  = 2'd3;

  localparam int KW_COUNT = 4;

  // Keyword spellings, padded with zeros to eight characters.
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd3, 8'd5, 8'd2, 8'd4};

  // Single-character tokens.
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_EQUAL = "=";
  localparam logic [7:0] CH_SEMI  = ";";

  // Input word: one text byte or a line end marker.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_word_t;

  // Output word: one token.
  typedef struct packed {
    logic [2:0] token_class;
    logic [1:0] keyword_id;
    logic [7:0] operator_char;
    logic [9:0] start_pos;
    logic [7:0] token_length;
    logic       truncated;
    logic       last_result;
  } tok_word_t;

  // Up to two tokens produced by one input word, first in first.
  typedef struct packed {
    logic      push0;
    logic      push1;
    tok_word_t tok0;
    tok_word_t tok1;
  } tok_pair_t;

  // Clear keyword flags that no longer match with byte c at token index idx.
  function automatic logic [3:0] kw_match(input logic [3:0] flags, input logic [7:0] c,
                                          input logic [7:0] idx);
    logic [3:0] res;
    res = flags;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!(idx < KW_LEN[k] && KW_TEXT[k][idx[2:0]] == c)) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/kinl_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
`default_nettype none

interface kinl_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/kinl_scan.sv
// Scanner state and token classification for one accepted input word.
`default_nettype none

module kinl_scan #(
  parameter int LINE_MAX  = 1024,
  parameter int TOKEN_MAX = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire kinl_pkg::in_word_t word,
  output kinl_pkg::tok_pair_t    pair
);

  localparam int PW = $clog2(LINE_MAX);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  mode_t         mode, mode_next;
  logic [PW-1:0] token_start, token_start_next;
  logic [7:0]    token_len, token_len_next;
  logic [3:0]    keyword_flags, keyword_flags_next;
  logic [PW-1:0] line_position, line_position_next;
  logic          overflow_seen, overflow_seen_next;

  logic [7:0]         c;
  logic               is_alpha, is_digit, is_op, is_semi, cont;
  kinl_pkg::tok_word_t pend, single;
  logic [PW+9:0]      start_ext, pos_ext;

  // Byte classes.
  assign c        = word.char_byte;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_op    = (c == kinl_pkg::CH_PLUS) || (c == kinl_pkg::CH_MINUS) ||
                    (c == kinl_pkg::CH_STAR) || (c == kinl_pkg::CH_SLASH) ||
                    (c == kinl_pkg::CH_EQUAL);
  assign is_semi  = (c == kinl_pkg::CH_SEMI);
  assign cont     = (mode == MODE_IDENT && (is_alpha || is_digit)) ||
                    (mode == MODE_NUMBER && is_digit);

  // Offsets are reported as their low ten bits.
  assign start_ext = {10'b0, token_start};
  assign pos_ext   = {10'b0, line_position};

  // The pending token as it would be emitted now.
  always_comb begin
    pend               = '0;
    pend.token_class   = (mode == MODE_NUMBER) ? kinl_pkg::CLS_NUMBER : kinl_pkg::CLS_IDENT;
    pend.start_pos     = start_ext[9:0];
    pend.token_length  = token_len;
    pend.truncated     = overflow_seen;
    if (mode == MODE_IDENT && !overflow_seen) begin
      for (int k = 0; k < kinl_pkg::KW_COUNT; k++) begin
        if (keyword_flags[k] && token_len == kinl_pkg::KW_LEN[k]) begin
          pend.token_class = kinl_pkg::CLS_KEYWORD;
          pend.keyword_id  = 2'(k);
        end
      end
    end
  end

  // A single-character operator or semicolon token at the current offset.
  always_comb begin
    single               = '0;
    single.token_class   = is_semi ? kinl_pkg::CLS_SEMICOLON : kinl_pkg::CLS_OPERATOR;
    single.operator_char = c;
    single.start_pos     = pos_ext[9:0];
    single.token_length  = 8'd1;
  end

  // Next state and the tokens this word produces.
  always_comb begin
    mode_next          = mode;
    token_start_next   = token_start;
    token_len_next     = token_len;
    keyword_flags_next = keyword_flags;
    line_position_next = line_position;
    overflow_seen_next = overflow_seen;
    pair               = '0;
    if (accept) begin
      if (word.end_of_line) begin
        if (mode != MODE_IDLE) begin
          pair.push0            = 1'b1;
          pair.tok0             = pend;
          pair.tok0.last_result = 1'b1;
        end
        mode_next          = MODE_IDLE;
        token_len_next     = 8'd0;
        overflow_seen_next = 1'b0;
        keyword_flags_next = 4'd0;
        line_position_next = '0;
      end else begin
        if (cont) begin
          if (mode == MODE_IDENT) begin
            keyword_flags_next = kinl_pkg::kw_match(keyword_flags, c, token_len);
          end
          if (token_len < 8'(TOKEN_MAX)) begin
            token_len_next = token_len + 8'd1;
          end else begin
            overflow_seen_next = 1'b1;
          end
        end else begin
          // The pending token ends here; then the byte is classified itself.
          if (mode != MODE_IDLE) begin
            pair.push0            = 1'b1;
            pair.tok0             = pend;
            pair.tok0.last_result = !(is_op || is_semi);
            mode_next             = MODE_IDLE;
            keyword_flags_next    = 4'd0;
          end
          if (is_alpha || is_digit) begin
            mode_next          = is_alpha ? MODE_IDENT : MODE_NUMBER;
            token_start_next   = line_position;
            token_len_next     = 8'd1;
            overflow_seen_next = 1'b0;
            keyword_flags_next = is_alpha ? kinl_pkg::kw_match(4'hF, c, 8'd0) : 4'd0;
          end else if (is_op || is_semi) begin
            if (mode != MODE_IDLE) begin
              pair.push1            = 1'b1;
              pair.tok1             = single;
              pair.tok1.last_result = 1'b1;
            end else begin
              pair.push0            = 1'b1;
              pair.tok0             = single;
              pair.tok0.last_result = 1'b1;
            end
          end
        end
        if (line_position < PW'(LINE_MAX - 1)) begin
          line_position_next = line_position + PW'(1);
        end
      end
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      token_start   <= '0;
      token_len     <= 8'd0;
      keyword_flags <= 4'd0;
      line_position <= '0;
      overflow_seen <= 1'b0;
    end else begin
      mode          <= mode_next;
      token_start   <= token_start_next;
      token_len     <= token_len_next;
      keyword_flags <= keyword_flags_next;
      line_position <= line_position_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

### design/kinl_outq.sv
// Four-entry token queue taking up to two words in and one word out per cycle.
`default_nettype none

module kinl_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kinl_pkg::tok_pair_t pair,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output kinl_pkg::tok_word_t     out_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  kinl_pkg::tok_word_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  // Space for a full pair is kept free before a new word is taken.
  assign room      = (count <= CW'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(pair.push0) + AW'(pair.push1);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(pair.push0) + CW'(pair.push1) - CW'(pop);
    end
  end

  // Token storage.
  always_ff @(posedge clk) begin
    if (pair.push0) begin
      entries[wr_ptr] <= pair.tok0;
    end
    if (pair.push1) begin
      entries[wr_ptr + AW'(1)] <= pair.tok1;
    end
  end

endmodule

`default_nettype wire

### design/keyword_ident_number_lexer.sv
// Top level of the streaming keyword, identifier and number lexer.
//
//   Channel    Direction  Word                      Handshake
//   char_in    sink       char_byte, end_of_line    valid/ready
//   token_out  source     one token per word        valid/ready
//
// A word is scanned in the cycle it is accepted and its tokens land in a
// four-entry queue, so a new byte can be taken every cycle while the queue has
// room for two tokens. An accepted word's first token is visible the next cycle
// if the queue was empty. Words yielding two tokens need two output handshakes,
// which sets the rate whenever the sink drains one token per cycle. Reset clears
// the scanner to idle at line offset zero and empties the queue.
`default_nettype none

module keyword_ident_number_lexer #(
  parameter int LINE_MAX  = 1024,
  parameter int TOKEN_MAX = 128
) (
  input wire logic      clk,
  input wire logic      rst,
  kinl_stream_if.sink   char_in,
  kinl_stream_if.source token_out
);

  kinl_pkg::in_word_t  in_word;
  kinl_pkg::tok_pair_t pair;
  kinl_pkg::tok_word_t out_word;
  logic                room;
  logic                accept;
  logic                out_valid;

  assign in_word       = char_in.data;
  assign char_in.ready = room;
  assign accept        = char_in.valid && room;

  // Scanner.
  kinl_scan #(
    .LINE_MAX  (LINE_MAX),
    .TOKEN_MAX (TOKEN_MAX)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (in_word),
    .pair   (pair)
  );

  // Token queue.
  kinl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (token_out.ready),
    .out_data  (out_word)
  );

  assign token_out.valid = out_valid;
  assign token_out.data  = out_word;

endmodule

`default_nettype wire
